FILE: hw/rtl/ctfd_pkg.sv
// ----------------------------------------------------------------------------
// CRTC timing from descriptor: shared package
// Field widths, constants and the structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package ctfd_pkg;

   // Input field widths
   localparam int CLK_W = 32;
   localparam int ACT_W = 12;
   localparam int HSO_W = 10;
   localparam int VSO_W = 6;

   // Derived widths
   localparam int POS_W = 13;                  // totals and sync positions
   localparam int TOT_W = 2 * POS_W;           // pixels per frame
   localparam int DVD_W = 39;                  // pixel clock times one hundred
   localparam int Q_W   = 16;                  // refresh quotient
   localparam int DSH_W = TOT_W + Q_W - 1;     // divisor aligned to the top quotient bit
   localparam int CMP_W = TOT_W + Q_W;         // overflow compare width

   // Divider organization
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

   // Scale factor for hundredths of a hertz
   localparam logic [DVD_W-1:0] CENTI = DVD_W'(100);

   // Result fields other than the refresh rate
   typedef struct packed {
      logic             valid_res;
      logic [POS_W-1:0] h_total;
      logic [POS_W-1:0] h_sync_begin;
      logic [POS_W-1:0] h_sync_finish;
      logic [POS_W-1:0] v_total;
      logic [POS_W-1:0] v_sync_begin;
      logic [POS_W-1:0] v_sync_finish;
      logic             hsync_neg;
      logic             vsync_neg;
      logic [CLK_W-1:0] pixel_clock;
   } ctfd_timing_type;

   // Divider state carried between stages
   typedef struct packed {
      ctfd_timing_type  timing;
      logic             rate_ok;
      logic [DVD_W-1:0] rem;
      logic [DSH_W-1:0] dsh;
      logic [Q_W-1:0]   quot;
   } ctfd_div_type;

endpackage

FILE: hw/rtl/ctfd_front.sv
// ----------------------------------------------------------------------------
// CRTC timing front end
// Three pipeline stages: timing sums and checks, frame size product, and the
// refresh overflow test that seeds the divider.
// ----------------------------------------------------------------------------
module ctfd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [ctfd_pkg::CLK_W-1:0] dot_clock,
   input  logic [ctfd_pkg::ACT_W-1:0] h_visible,
   input  logic [ctfd_pkg::ACT_W-1:0] h_blank,
   input  logic [ctfd_pkg::HSO_W-1:0] h_front_porch,
   input  logic [ctfd_pkg::HSO_W-1:0] h_sync_len,
   input  logic [ctfd_pkg::ACT_W-1:0] v_visible,
   input  logic [ctfd_pkg::ACT_W-1:0] v_blank,
   input  logic [ctfd_pkg::VSO_W-1:0] v_front_porch,
   input  logic [ctfd_pkg::VSO_W-1:0] v_sync_len,
   input  logic                       hsync_neg_in,
   input  logic                       vsync_neg_in,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ctfd_pkg::ctfd_div_type     out_data
);
   import ctfd_pkg::*;

   logic             a_vld_ff, b_vld_ff, c_vld_ff;
   logic             a_rdy, b_rdy, c_rdy;
   ctfd_timing_type  a_tim_ff, a_tim_in;
   logic [DVD_W-1:0] a_dvd_ff, a_dvd_in;
   ctfd_timing_type  b_tim_ff;
   logic [DVD_W-1:0] b_dvd_ff;
   logic [TOT_W-1:0] b_tot_ff, b_tot_in;
   ctfd_div_type     c_dat_ff, c_dat_in;
   logic [POS_W-1:0] ht, hs, he, vt, vs, ve;
   logic             ok;

   // A stage takes a new transaction when it is empty or its content moves on.
   assign c_rdy    = !c_vld_ff || out_ready;
   assign b_rdy    = !b_vld_ff || c_rdy;
   assign a_rdy    = !a_vld_ff || b_rdy;
   assign in_ready = a_rdy;

   // Stage A: line and frame positions, descriptor checks, scaled clock.
   always_comb begin
      ht = POS_W'(h_visible) + POS_W'(h_blank);
      hs = POS_W'(h_visible) + POS_W'(h_front_porch);
      he = hs + POS_W'(h_sync_len);
      vt = POS_W'(v_visible) + POS_W'(v_blank);
      vs = POS_W'(v_visible) + POS_W'(v_front_porch);
      ve = vs + POS_W'(v_sync_len);
      ok = (dot_clock != '0) && (h_visible != '0) && (v_visible != '0) &&
           (h_blank != '0) && (v_blank != '0) && (he <= ht) && (ve <= vt);
      a_tim_in = '0;
      a_dvd_in = '0;
      if (ok) begin
         a_tim_in.valid_res     = 1'b1;
         a_tim_in.h_total       = ht;
         a_tim_in.h_sync_begin  = hs;
         a_tim_in.h_sync_finish = he;
         a_tim_in.v_total       = vt;
         a_tim_in.v_sync_begin  = vs;
         a_tim_in.v_sync_finish = ve;
         a_tim_in.hsync_neg     = hsync_neg_in;
         a_tim_in.vsync_neg     = vsync_neg_in;
         a_tim_in.pixel_clock   = dot_clock;
         a_dvd_in               = DVD_W'(dot_clock) * CENTI;
      end
   end

   // Stage B: pixels per frame. A refused descriptor carries zero totals.
   assign b_tot_in = TOT_W'(a_tim_ff.h_total) * TOT_W'(a_tim_ff.v_total);

   // Stage C: a quotient above the 16-bit range gives a zero rate.
   always_comb begin
      c_dat_in         = '0;
      c_dat_in.timing  = b_tim_ff;
      c_dat_in.rate_ok = b_tim_ff.valid_res &&
                         (CMP_W'(b_dvd_ff) < {b_tot_ff, {Q_W{1'b0}}});
      c_dat_in.rem     = b_dvd_ff;
      c_dat_in.dsh     = {b_tot_ff, {(Q_W-1){1'b0}}};
      c_dat_in.quot    = '0;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) a_vld_ff <= in_valid;
         if (b_rdy) b_vld_ff <= a_vld_ff;
         if (c_rdy) c_vld_ff <= b_vld_ff;
      end
   end

   // Payload registers load only with a moving transaction.
   always_ff @(posedge clock) begin
      if (a_rdy && in_valid) begin
         a_tim_ff <= a_tim_in;
         a_dvd_ff <= a_dvd_in;
      end
      if (b_rdy && a_vld_ff) begin
         b_tim_ff <= a_tim_ff;
         b_dvd_ff <= a_dvd_ff;
         b_tot_ff <= b_tot_in;
      end
      if (c_rdy && b_vld_ff) begin
         c_dat_ff <= c_dat_in;
      end
   end

   assign out_valid = c_vld_ff;
   assign out_data  = c_dat_ff;

endmodule

FILE: hw/rtl/ctfd_div_stage.sv
// ----------------------------------------------------------------------------
// CRTC timing divider stage
// One registered step of the restoring divider, retiring two quotient bits.
// ----------------------------------------------------------------------------
module ctfd_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctfd_pkg::ctfd_div_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ctfd_pkg::ctfd_div_type out_data
);
   import ctfd_pkg::*;

   logic             vld_ff;
   ctfd_div_type     dat_ff, dat_in;
   logic [DVD_W-1:0] r;
   logic [DSH_W-1:0] d;
   logic [Q_W-1:0]   q;

   assign in_ready = !vld_ff || out_ready;

   // Compare and subtract the aligned divisor, then move it one bit down.
   always_comb begin
      r = in_data.rem;
      d = in_data.dsh;
      q = in_data.quot;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         if (DSH_W'(r) >= d) begin
            r = DVD_W'(DSH_W'(r) - d);
            q = {q[Q_W-2:0], 1'b1};
         end else begin
            q = {q[Q_W-2:0], 1'b0};
         end
         d = d >> 1;
      end
      dat_in      = in_data;
      dat_in.rem  = r;
      dat_in.dsh  = d;
      dat_in.quot = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dat_ff <= dat_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = dat_ff;

endmodule

FILE: hw/rtl/crtc_timing_from_descriptor_core.sv
// ----------------------------------------------------------------------------
// CRTC timing from descriptor
// Turns a display timing descriptor into CRTC totals, sync positions and the
// refresh rate in hundredths of a hertz.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake               Contents
//   req_      in          req_valid / req_ready   one timing descriptor
//   rsp_      out         rsp_valid / rsp_ready   one CRTC timing result
//
// An accepted transaction passes through three front stages
// (sums and checks, frame size product, overflow test) and eight divider
// stages that each retire two bits of the 16-bit refresh quotient.
// One transaction is accepted per cycle while the result side keeps up.
// Every stage holds its content while the stage after it is full and stalled;
// empty stages still fill, so bubbles are squeezed out.
// Reset clears the valid bits only; the payload registers are not reset.
// ----------------------------------------------------------------------------
module crtc_timing_from_descriptor_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ctfd_pkg::CLK_W-1:0] req_dot_clock,
   input  logic [ctfd_pkg::ACT_W-1:0] req_h_visible,
   input  logic [ctfd_pkg::ACT_W-1:0] req_h_blank,
   input  logic [ctfd_pkg::HSO_W-1:0] req_h_front_porch,
   input  logic [ctfd_pkg::HSO_W-1:0] req_h_sync_len,
   input  logic [ctfd_pkg::ACT_W-1:0] req_v_visible,
   input  logic [ctfd_pkg::ACT_W-1:0] req_v_blank,
   input  logic [ctfd_pkg::VSO_W-1:0] req_v_front_porch,
   input  logic [ctfd_pkg::VSO_W-1:0] req_v_sync_len,
   input  logic                       req_hsync_neg_in,
   input  logic                       req_vsync_neg_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_valid_res,
   output logic [ctfd_pkg::POS_W-1:0] rsp_h_total,
   output logic [ctfd_pkg::POS_W-1:0] rsp_h_sync_begin,
   output logic [ctfd_pkg::POS_W-1:0] rsp_h_sync_finish,
   output logic [ctfd_pkg::POS_W-1:0] rsp_v_total,
   output logic [ctfd_pkg::POS_W-1:0] rsp_v_sync_begin,
   output logic [ctfd_pkg::POS_W-1:0] rsp_v_sync_finish,
   output logic                       rsp_hsync_neg_out,
   output logic                       rsp_vsync_neg_out,
   output logic [ctfd_pkg::CLK_W-1:0] rsp_pixel_clock_out,
   output logic [ctfd_pkg::Q_W-1:0]   rsp_refresh_centihz
);
   import ctfd_pkg::*;

   logic         vld [DIV_STAGES+1];
   logic         rdy [DIV_STAGES+1];
   ctfd_div_type dat [DIV_STAGES+1];
   ctfd_div_type last;

   // Front stages: checks, products and divider seed.
   ctfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .dot_clock      (req_dot_clock),
      .h_visible      (req_h_visible),
      .h_blank        (req_h_blank),
      .h_front_porch  (req_h_front_porch),
      .h_sync_len     (req_h_sync_len),
      .v_visible      (req_v_visible),
      .v_blank        (req_v_blank),
      .v_front_porch  (req_v_front_porch),
      .v_sync_len     (req_v_sync_len),
      .hsync_neg_in   (req_hsync_neg_in),
      .vsync_neg_in   (req_vsync_neg_in),
      .out_valid      (vld[0]),
      .out_ready      (rdy[0]),
      .out_data       (dat[0])
   );

   // Divider chain for the refresh quotient.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      ctfd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[s]),
         .in_ready  (rdy[s]),
         .in_data   (dat[s]),
         .out_valid (vld[s+1]),
         .out_ready (rdy[s+1]),
         .out_data  (dat[s+1])
      );
   end

   assign rdy[DIV_STAGES] = rsp_ready;
   assign last            = dat[DIV_STAGES];

   // Result fields from the last divider register.
   assign rsp_valid           = vld[DIV_STAGES];
   assign rsp_valid_res       = last.timing.valid_res;
   assign rsp_h_total         = last.timing.h_total;
   assign rsp_h_sync_begin    = last.timing.h_sync_begin;
   assign rsp_h_sync_finish   = last.timing.h_sync_finish;
   assign rsp_v_total         = last.timing.v_total;
   assign rsp_v_sync_begin    = last.timing.v_sync_begin;
   assign rsp_v_sync_finish   = last.timing.v_sync_finish;
   assign rsp_hsync_neg_out   = last.timing.hsync_neg;
   assign rsp_vsync_neg_out   = last.timing.vsync_neg;
   assign rsp_pixel_clock_out = last.timing.pixel_clock;
   assign rsp_refresh_centihz = last.rate_ok ? last.quot : '0;

endmodule

FILE: hw/rtl/ctfd_checker.sv
// ----------------------------------------------------------------------------
// CRTC timing from descriptor: port checker
// Watches the top-level ports for result consistency and output stalls.
// ----------------------------------------------------------------------------
module ctfd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_valid_res,
   input logic [ctfd_pkg::POS_W-1:0] rsp_h_total,
   input logic [ctfd_pkg::POS_W-1:0] rsp_h_sync_begin,
   input logic [ctfd_pkg::POS_W-1:0] rsp_h_sync_finish,
   input logic [ctfd_pkg::POS_W-1:0] rsp_v_total,
   input logic [ctfd_pkg::POS_W-1:0] rsp_v_sync_begin,
   input logic [ctfd_pkg::POS_W-1:0] rsp_v_sync_finish,
   input logic                       rsp_hsync_neg_out,
   input logic                       rsp_vsync_neg_out,
   input logic [ctfd_pkg::CLK_W-1:0] rsp_pixel_clock_out,
   input logic [ctfd_pkg::Q_W-1:0]   rsp_refresh_centihz
);
   import ctfd_pkg::*;

   // A refused descriptor comes out with its totals, sync ends, clock, refresh and polarities cleared.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_h_total == '0 && rsp_v_total == '0 && rsp_h_sync_finish == '0 &&
         rsp_v_sync_finish == '0 && rsp_pixel_clock_out == '0 &&
         rsp_refresh_centihz == '0 && !rsp_hsync_neg_out && !rsp_vsync_neg_out)
      else $error("refused result carries nonzero fields");

   // An accepted descriptor keeps both sync pulses inside their totals.
   a_sync_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
         rsp_h_sync_begin <= rsp_h_sync_finish && rsp_h_sync_finish <= rsp_h_total &&
         rsp_v_sync_begin <= rsp_v_sync_finish && rsp_v_sync_finish <= rsp_v_total)
      else $error("sync positions out of order");

   // An accepted descriptor has a running clock and nonempty lines and frames.
   a_accepted_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
         rsp_pixel_clock_out != '0 && rsp_h_total >= POS_W'(2) &&
         rsp_v_total >= POS_W'(2))
      else $error("accepted result with empty timing");

   // A stalled result transaction holds its refresh value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_refresh_centihz))
      else $error("stalled result changed");

endmodule

bind crtc_timing_from_descriptor_core ctfd_checker u_ctfd_checker (.*);

FILE: verif/tb_crtc_timing_from_descriptor_core.sv
// ----------------------------------------------------------------------------
// CRTC timing from descriptor: self-checking testbench
// Drives timing descriptors into the core and checks every result against a
// behavioral predictor. A directed table covers refused descriptors, sync
// ends on the total, refresh overflow and field extremes. Random descriptors
// follow, mostly well-formed and partly broken or fully random. Both sides
// idle in random bursts, the receiver holds off long enough to back up the
// pipeline, and the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_crtc_timing_from_descriptor_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ctfd_pkg::*;

   localparam int          RESET_CYCLES    = 7;
   localparam int          HOLD_OFF_CYCLES = 100;
   localparam int          PRESSURE_ITEMS  = 40;
   localparam int          SEGMENTS        = 10;
   localparam int          SEGMENT_ITEMS   = 120;
   localparam int          QUIET_SEGMENTS  = 2;
   localparam int          SETTLE_CYCLES   = 40;
   localparam int          REPORT_LIMIT    = 10;
   localparam int          NUM_ROWS        = 22;
   localparam logic [63:0] CENTI_SCALE     = 64'd100;
   localparam logic [63:0] REFRESH_MAX     = 64'hFFFF;
   localparam logic        TYPED           = 1'b1;
   localparam logic        PREDICTED       = 1'b0;

   // One display timing descriptor as it appears on the request ports.
   typedef struct packed {
      logic [CLK_W-1:0] dot_clock;
      logic [ACT_W-1:0] h_visible;
      logic [ACT_W-1:0] h_blank;
      logic [HSO_W-1:0] h_front_porch;
      logic [HSO_W-1:0] h_sync_len;
      logic [ACT_W-1:0] v_visible;
      logic [ACT_W-1:0] v_blank;
      logic [VSO_W-1:0] v_front_porch;
      logic [VSO_W-1:0] v_sync_len;
      logic             hsync_neg_in;
      logic             vsync_neg_in;
   } crtc_descriptor_type;

   // One CRTC timing result as it appears on the response ports.
   typedef struct packed {
      logic             valid_res;
      logic [POS_W-1:0] h_total;
      logic [POS_W-1:0] h_sync_begin;
      logic [POS_W-1:0] h_sync_finish;
      logic [POS_W-1:0] v_total;
      logic [POS_W-1:0] v_sync_begin;
      logic [POS_W-1:0] v_sync_finish;
      logic             hsync_neg_out;
      logic             vsync_neg_out;
      logic [CLK_W-1:0] pixel_clock_out;
      logic [Q_W-1:0]   refresh_centihz;
   } crtc_result_type;

   typedef struct packed {
      logic                typed;
      crtc_descriptor_type desc;
      crtc_result_type     result;
   } directed_row_type;

   localparam crtc_result_type REFUSED = '0;

   // Directed descriptors. Refused rows and simple extremes carry their
   // result typed in; the others are predicted.
   directed_row_type directed_rows [NUM_ROWS] = '{
      // Zero pixel clock.
      '{TYPED, '{0, 640, 160, 16, 96, 480, 45, 10, 2, 1, 1}, REFUSED},
      // Zero active width.
      '{TYPED, '{25175000, 0, 160, 16, 96, 480, 45, 10, 2, 0, 0}, REFUSED},
      // Zero horizontal blank.
      '{TYPED, '{25175000, 640, 0, 0, 0, 480, 45, 10, 2, 0, 1}, REFUSED},
      // Zero active height.
      '{TYPED, '{25175000, 640, 160, 16, 96, 0, 45, 10, 2, 1, 0}, REFUSED},
      // Zero vertical blank.
      '{TYPED, '{25175000, 640, 160, 16, 96, 480, 0, 0, 0, 1, 1}, REFUSED},
      // Horizontal sync end one past the line total.
      '{TYPED, '{25175000, 640, 160, 64, 97, 480, 45, 10, 2, 0, 0}, REFUSED},
      // Vertical sync end one past the frame total.
      '{TYPED, '{25175000, 640, 160, 16, 96, 480, 45, 40, 6, 0, 0}, REFUSED},
      // Everything zero.
      '{TYPED, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, REFUSED},
      // Smallest accepted descriptor.
      '{TYPED, '{1, 1, 1, 0, 0, 1, 1, 0, 0, 0, 0},
                '{1, 2, 1, 1, 2, 1, 1, 0, 0, 1, 25}},
      // Every field at its maximum.
      '{TYPED, '{32'hFFFF_FFFF, 4095, 4095, 1023, 1023, 4095, 4095, 63, 63, 1, 1},
                '{1, 8190, 5118, 6141, 8190, 4158, 4221, 1, 1, 32'hFFFF_FFFF, 6403}},
      // Refresh far above the limit is reported as zero but still accepted.
      '{TYPED, '{32'hFFFF_FFFF, 1, 1, 0, 0, 1, 1, 0, 0, 1, 0},
                '{1, 2, 1, 1, 2, 1, 1, 1, 0, 32'hFFFF_FFFF, 0}},
      // Refresh exactly at the limit.
      '{TYPED, '{65535, 5, 5, 0, 0, 5, 5, 0, 0, 0, 1},
                '{1, 10, 5, 5, 10, 5, 5, 0, 1, 65535, 65535}},
      // Refresh one above the limit.
      '{TYPED, '{65536, 5, 5, 0, 0, 5, 5, 0, 0, 0, 1},
                '{1, 10, 5, 5, 10, 5, 5, 0, 1, 65536, 0}},
      // Horizontal sync end lands on the line total.
      '{PREDICTED, '{25175000, 640, 160, 64, 96, 480, 45, 10, 2, 1, 0}, REFUSED},
      // Vertical sync end lands on the frame total.
      '{PREDICTED, '{25175000, 640, 160, 16, 96, 480, 45, 40, 5, 0, 1}, REFUSED},
      // Common 640x480 mode.
      '{PREDICTED, '{25175000, 640, 160, 16, 96, 480, 45, 10, 2, 1, 1}, REFUSED},
      // Common 1920x1080 mode.
      '{PREDICTED, '{148500000, 1920, 280, 88, 44, 1080, 45, 4, 5, 0, 0}, REFUSED},
      // Large clock over a small frame, where a narrow remainder would wrap.
      '{PREDICTED, '{32'd4000000000, 2048, 2048, 100, 50, 1, 63, 1, 1, 0, 1}, REFUSED},
      // Widest sync over a one-line active frame.
      '{PREDICTED, '{300000000, 4095, 4095, 1023, 1023, 1, 4095, 63, 63, 1, 0},
                   REFUSED},
      // Line total just past the 12-bit range.
      '{PREDICTED, '{100000000, 4095, 1, 1, 0, 4095, 1, 1, 0, 0, 0}, REFUSED},
      // Sync offset and width both at maximum, ending on the total.
      '{PREDICTED, '{162000000, 1600, 2046, 1023, 1023, 1200, 126, 63, 63, 1, 1},
                   REFUSED},
      // Small totals with a mid-range clock.
      '{PREDICTED, '{123457, 3, 7, 2, 5, 9, 11, 3, 8, 0, 1}, REFUSED}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CLK_W-1:0] req_dot_clock = '0;
   logic [ACT_W-1:0] req_h_visible = '0;
   logic [ACT_W-1:0] req_h_blank = '0;
   logic [HSO_W-1:0] req_h_front_porch = '0;
   logic [HSO_W-1:0] req_h_sync_len = '0;
   logic [ACT_W-1:0] req_v_visible = '0;
   logic [ACT_W-1:0] req_v_blank = '0;
   logic [VSO_W-1:0] req_v_front_porch = '0;
   logic [VSO_W-1:0] req_v_sync_len = '0;
   logic             req_hsync_neg_in = 1'b0;
   logic             req_vsync_neg_in = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_valid_res;
   logic [POS_W-1:0] rsp_h_total;
   logic [POS_W-1:0] rsp_h_sync_begin;
   logic [POS_W-1:0] rsp_h_sync_finish;
   logic [POS_W-1:0] rsp_v_total;
   logic [POS_W-1:0] rsp_v_sync_begin;
   logic [POS_W-1:0] rsp_v_sync_finish;
   logic             rsp_hsync_neg_out;
   logic             rsp_vsync_neg_out;
   logic [CLK_W-1:0] rsp_pixel_clock_out;
   logic [Q_W-1:0]   rsp_refresh_centihz;

   // Results of descriptors on offer, then of accepted ones in order.
   crtc_result_type pending_offers [$];
   crtc_result_type expected_timings [$];

   int failures      = 0;
   int responses     = 0;
   bit sender_gaps   = 1'b1;
   bit receiver_stalls = 1'b1;
   bit hold_off_request = 1'b0;

   crtc_timing_from_descriptor_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_dot_clock       (req_dot_clock),
      .req_h_visible       (req_h_visible),
      .req_h_blank         (req_h_blank),
      .req_h_front_porch   (req_h_front_porch),
      .req_h_sync_len      (req_h_sync_len),
      .req_v_visible       (req_v_visible),
      .req_v_blank         (req_v_blank),
      .req_v_front_porch   (req_v_front_porch),
      .req_v_sync_len      (req_v_sync_len),
      .req_hsync_neg_in    (req_hsync_neg_in),
      .req_vsync_neg_in    (req_vsync_neg_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_h_total         (rsp_h_total),
      .rsp_h_sync_begin    (rsp_h_sync_begin),
      .rsp_h_sync_finish   (rsp_h_sync_finish),
      .rsp_v_total         (rsp_v_total),
      .rsp_v_sync_begin    (rsp_v_sync_begin),
      .rsp_v_sync_finish   (rsp_v_sync_finish),
      .rsp_hsync_neg_out   (rsp_hsync_neg_out),
      .rsp_vsync_neg_out   (rsp_vsync_neg_out),
      .rsp_pixel_clock_out (rsp_pixel_clock_out),
      .rsp_refresh_centihz (rsp_refresh_centihz)
   );

   always #6 clock = ~clock;

   // Derive the CRTC timing of one descriptor, or all zeros when refused.
   function automatic crtc_result_type predict_crtc_timing(input crtc_descriptor_type d);
      crtc_result_type r;
      logic [63:0]     ht, hs, he, vt, vs, ve, frame, rate;
      r = '0;
      if (d.dot_clock == 0 || d.h_visible == 0 || d.v_visible == 0 ||
          d.h_blank == 0 || d.v_blank == 0) begin
         return r;
      end
      ht = 64'(d.h_visible) + 64'(d.h_blank);
      hs = 64'(d.h_visible) + 64'(d.h_front_porch);
      he = hs + 64'(d.h_sync_len);
      vt = 64'(d.v_visible) + 64'(d.v_blank);
      vs = 64'(d.v_visible) + 64'(d.v_front_porch);
      ve = vs + 64'(d.v_sync_len);
      if (he > ht || ve > vt) begin
         return r;
      end
      // Exact quotient in wide arithmetic; anything over 16 bits reads as zero.
      frame = ht * vt;
      rate  = (64'(d.dot_clock) * CENTI_SCALE) / frame;
      if (rate > REFRESH_MAX) begin
         rate = '0;
      end
      r.valid_res       = 1'b1;
      r.h_total         = POS_W'(ht);
      r.h_sync_begin    = POS_W'(hs);
      r.h_sync_finish   = POS_W'(he);
      r.v_total         = POS_W'(vt);
      r.v_sync_begin    = POS_W'(vs);
      r.v_sync_finish   = POS_W'(ve);
      r.hsync_neg_out   = d.hsync_neg_in;
      r.vsync_neg_out   = d.vsync_neg_in;
      r.pixel_clock_out = d.dot_clock;
      r.refresh_centihz = Q_W'(rate);
      return r;
   endfunction

   // Pick a descriptor: mostly well-formed, some broken, some fully random.
   function automatic crtc_descriptor_type random_descriptor();
      crtc_descriptor_type d;
      int                  kind, h_room, v_room;
      logic [63:0]         edge_clock;
      kind = $urandom_range(0, 99);
      d.hsync_neg_in = 1'($urandom_range(0, 1));
      d.vsync_neg_in = 1'($urandom_range(0, 1));
      if (kind >= 70 && kind < 85) begin
         d.dot_clock     = $urandom();
         d.h_visible     = ACT_W'($urandom());
         d.h_blank       = ACT_W'($urandom());
         d.h_front_porch = HSO_W'($urandom());
         d.h_sync_len    = HSO_W'($urandom());
         d.v_visible     = ACT_W'($urandom());
         d.v_blank       = ACT_W'($urandom());
         d.v_front_porch = VSO_W'($urandom());
         d.v_sync_len    = VSO_W'($urandom());
         return d;
      end
      // Well-formed geometry, small sizes now and then.
      d.h_visible = ACT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 4095));
      d.h_blank   = ACT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 4095));
      d.v_visible = ACT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 4095));
      d.v_blank   = ACT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 4095));
      h_room = (d.h_blank > 1023) ? 1023 : int'(d.h_blank);
      d.h_front_porch = HSO_W'($urandom_range(0, h_room));
      h_room = int'(d.h_blank) - int'(d.h_front_porch);
      d.h_sync_len = HSO_W'($urandom_range(0, (h_room > 1023) ? 1023 : h_room));
      v_room = (d.v_blank > 63) ? 63 : int'(d.v_blank);
      d.v_front_porch = VSO_W'($urandom_range(0, v_room));
      v_room = int'(d.v_blank) - int'(d.v_front_porch);
      d.v_sync_len = VSO_W'($urandom_range(0, (v_room > 63) ? 63 : v_room));
      // Clock: tiny, typical, anything, or right around the refresh limit.
      case ($urandom_range(0, 3))
         0: d.dot_clock = $urandom_range(1, 1000);
         1: d.dot_clock = $urandom_range(10_000_000, 600_000_000);
         2: d.dot_clock = ($urandom() | 32'd1);
         default: begin
            edge_clock = ((REFRESH_MAX + 1) * (64'(d.h_visible) + 64'(d.h_blank)) *
                          (64'(d.v_visible) + 64'(d.v_blank))) / CENTI_SCALE;
            if (edge_clock > 64'hFFFF_FF00 || edge_clock < 64'd4) begin
               d.dot_clock = $urandom() | 32'd1;
            end else begin
               d.dot_clock = CLK_W'(edge_clock - 2 + $urandom_range(0, 4));
            end
         end
      endcase
      if (kind >= 85) begin
         // Break one rule of an otherwise sane descriptor.
         case ($urandom_range(0, 6))
            0: d.dot_clock = '0;
            1: d.h_visible = '0;
            2: d.h_blank = '0;
            3: d.v_visible = '0;
            4: d.v_blank = '0;
            5: begin
               d.h_blank       = ACT_W'($urandom_range(1, 1000));
               d.h_front_porch = HSO_W'($urandom_range(0, d.h_blank));
               h_room          = int'(d.h_blank) - int'(d.h_front_porch);
               d.h_sync_len    = HSO_W'(h_room + $urandom_range(1, 1023 - h_room));
            end
            default: begin
               d.v_blank       = ACT_W'($urandom_range(1, 60));
               d.v_front_porch = VSO_W'($urandom_range(0, d.v_blank));
               v_room          = int'(d.v_blank) - int'(d.v_front_porch);
               d.v_sync_len    = VSO_W'(v_room + $urandom_range(1, 63 - v_room));
            end
         endcase
      end
      return d;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         note_failure($sformatf("response %0d %s: expected %0h, got %0h",
                                responses, name, want, got));
      end
   endfunction

   // Offer one descriptor, with an optional idle burst first, and hold it
   // until the core takes it.
   task automatic offer_descriptor(input crtc_descriptor_type d,
                                   input crtc_result_type want);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_dot_clock     <= d.dot_clock;
      req_h_visible     <= d.h_visible;
      req_h_blank       <= d.h_blank;
      req_h_front_porch <= d.h_front_porch;
      req_h_sync_len    <= d.h_sync_len;
      req_v_visible     <= d.v_visible;
      req_v_blank       <= d.v_blank;
      req_v_front_porch <= d.v_front_porch;
      req_v_sync_len    <= d.v_sync_len;
      req_hsync_neg_in  <= d.hsync_neg_in;
      req_vsync_neg_in  <= d.vsync_neg_in;
      pending_offers.push_back(want);
      do @(posedge clock); while (!req_ready);
   endtask

   // Draw one random descriptor and offer it with its predicted timing.
   task automatic send_random();
      crtc_descriptor_type d;
      d = random_descriptor();
      offer_descriptor(d, predict_crtc_timing(d));
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_offers.size() != 0 || expected_timings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Track accepted descriptors and check each response transaction in order.
   always @(posedge clock) begin : scoreboard
      crtc_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_timings.push_back(pending_offers.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_timings.size() == 0) begin
               note_failure($sformatf("response %0d arrived with nothing expected",
                                      responses));
            end else begin
               want = expected_timings.pop_front();
               check_field("valid_res", 32'(want.valid_res), 32'(rsp_valid_res));
               check_field("h_total", 32'(want.h_total), 32'(rsp_h_total));
               check_field("h_sync_begin", 32'(want.h_sync_begin), 32'(rsp_h_sync_begin));
               check_field("h_sync_finish", 32'(want.h_sync_finish),
                           32'(rsp_h_sync_finish));
               check_field("v_total", 32'(want.v_total), 32'(rsp_v_total));
               check_field("v_sync_begin", 32'(want.v_sync_begin), 32'(rsp_v_sync_begin));
               check_field("v_sync_finish", 32'(want.v_sync_finish),
                           32'(rsp_v_sync_finish));
               check_field("hsync_neg_out", 32'(want.hsync_neg_out),
                           32'(rsp_hsync_neg_out));
               check_field("vsync_neg_out", 32'(want.vsync_neg_out),
                           32'(rsp_vsync_neg_out));
               check_field("pixel_clock_out", want.pixel_clock_out, rsp_pixel_clock_out);
               check_field("refresh_centihz", 32'(want.refresh_centihz),
                           32'(rsp_refresh_centihz));
            end
            responses++;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      int held;
      bit hold_done;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_done) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
               @(posedge clock);
            end
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main stimulus sequence.
   initial begin : stimulus
      int i, seg;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (i = 0; i < NUM_ROWS; i++) begin
         offer_descriptor(directed_rows[i].desc,
                          directed_rows[i].typed ? directed_rows[i].result
                                                 : predict_crtc_timing(directed_rows[i].desc));
      end
      wait_drained();

      // Back up the pipeline behind a long hold-off, then let it empty out.
      sender_gaps      = 1'b0;
      hold_off_request = 1'b1;
      for (i = 0; i < PRESSURE_ITEMS; i++) begin
         send_random();
      end
      wait_drained();

      // Random segments with varying idling; the last ones run at full rate.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         sender_gaps     = (seg < SEGMENTS - QUIET_SEGMENTS) ? 1'($urandom_range(0, 1)) : 1'b0;
         receiver_stalls = (seg < SEGMENTS - QUIET_SEGMENTS) ? 1'($urandom_range(0, 1)) : 1'b0;
         for (i = 0; i < SEGMENT_ITEMS; i++) begin
            send_random();
         end
      end
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && expected_timings.size() == 0) begin
         $display("PASS crtc_timing_from_descriptor_core");
      end else begin
         $display("FAIL crtc_timing_from_descriptor_core");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("FAIL crtc_timing_from_descriptor_core");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ctfd_pkg.sv
hw/rtl/ctfd_front.sv
hw/rtl/ctfd_div_stage.sv
hw/rtl/crtc_timing_from_descriptor_core.sv
hw/rtl/ctfd_checker.sv
verif/tb_crtc_timing_from_descriptor_core.sv
